>>> design/cbmf_pkg.sv
// Shared constants, types and the fixed-point weight table for the colour matrix filter.
package cbmf_pkg;

    localparam int COEF_FRAC_BITS = 10;
    localparam int PIX_W          = 8;
    localparam int CH_N           = 3;
    localparam int N_PRESET       = 8;
    localparam int SEL_W          = $clog2(N_PRESET);
    localparam int PROD_W         = PIX_W + COEF_FRAC_BITS;
    localparam int SUM_W          = PROD_W + 2;
    localparam int PCT_SCALE      = 100;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [PIX_W-1:0]          t_pix;
    typedef t_pix [CH_N-1:0]           t_rgb;
    typedef logic [COEF_FRAC_BITS-1:0] t_coef;
    typedef t_coef [CH_N-1:0]          t_row;
    typedef t_row [CH_N-1:0]           t_mat;
    typedef t_mat [N_PRESET-1:0]       t_mat_tab;
    typedef logic [PROD_W-1:0]         t_prod;
    typedef t_prod [CH_N-1:0]          t_prod_row;
    typedef t_prod_row [CH_N-1:0]      t_prod_mat;
    typedef logic [SEL_W-1:0]          t_sel;

    // Weights in hundredths, indexed by preset, output channel and input channel.
    localparam int WEIGHT_PCT [N_PRESET][CH_N][CH_N] = '{
        '{'{56, 44,  0}, '{55, 45,  0}, '{ 0, 24, 76}},
        '{'{82, 18,  0}, '{33, 67,  0}, '{ 0, 13, 87}},
        '{'{63, 37,  0}, '{70, 30,  0}, '{ 0, 30, 70}},
        '{'{80, 20,  0}, '{26, 74,  0}, '{ 0, 15, 85}},
        '{'{95,  5,  0}, '{ 0, 44, 56}, '{ 0, 48, 52}},
        '{'{97,  3,  0}, '{ 0, 73, 27}, '{ 0, 18, 82}},
        '{'{30, 59, 11}, '{30, 59, 11}, '{30, 59, 11}},
        '{'{62, 32,  6}, '{16, 78,  6}, '{16, 32, 52}}
    };

    function automatic t_mat_tab calc_weights();
        t_mat_tab tab;
        int       pct;
        for (int p = 0; p < N_PRESET; p++) begin
            for (int o = 0; o < CH_N; o++) begin
                for (int i = 0; i < CH_N; i++) begin
                    pct = WEIGHT_PCT[p][o][i];
                    tab[p][o][i] = COEF_FRAC_BITS'(
                        (pct * (1 << COEF_FRAC_BITS) + PCT_SCALE / 2) / PCT_SCALE);
                end
            end
        end
        return tab;
    endfunction

    localparam t_mat_tab WEIGHT_FX = calc_weights();

endpackage

>>> design/cbmf_coef.sv
// First pipeline stage: registers the pixel and looks up the weight matrix of the preset.
module cbmf_coef (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cbmf_pkg::t_rgb i_rgb,
    input  cbmf_pkg::t_pix i_alpha,
    input  cbmf_pkg::t_sel i_preset,
    output logic           o_valid,
    input  logic           i_stall,
    output cbmf_pkg::t_rgb o_rgb,
    output cbmf_pkg::t_pix o_alpha,
    output cbmf_pkg::t_mat o_mat
);
    import cbmf_pkg::*;

    logic r_valid;
    t_rgb r_rgb;
    t_pix r_alpha;
    t_mat r_mat;
    logic load;

    assign o_stall = r_valid & i_stall;
    assign load    = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_rgb   <= i_rgb;
            r_alpha <= i_alpha;
            r_mat   <= WEIGHT_FX[i_preset];
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;
    assign o_alpha = r_alpha;
    assign o_mat   = r_mat;

endmodule

>>> design/cbmf_mult.sv
// Second pipeline stage: the nine channel by weight products.
module cbmf_mult (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cbmf_pkg::t_rgb      i_rgb,
    input  cbmf_pkg::t_pix      i_alpha,
    input  cbmf_pkg::t_mat      i_mat,
    output logic                o_valid,
    input  logic                i_stall,
    output cbmf_pkg::t_prod_mat o_prod,
    output cbmf_pkg::t_pix      o_alpha
);
    import cbmf_pkg::*;

    logic      r_valid;
    t_prod_mat r_prod;
    t_pix      r_alpha;
    t_prod_mat n_prod;
    logic      load;

    assign o_stall = r_valid & i_stall;
    assign load    = ~o_stall;

    always_comb begin
        for (int o = 0; o < CH_N; o++) begin
            for (int i = 0; i < CH_N; i++) begin
                n_prod[o][i] = PROD_W'(i_rgb[i]) * PROD_W'(i_mat[o][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_prod  <= n_prod;
            r_alpha <= i_alpha;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_alpha = r_alpha;

endmodule

>>> design/cbmf_sum.sv
// Third pipeline stage: row sums, fraction truncation and saturation into the output register.
module cbmf_sum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cbmf_pkg::t_prod_mat i_prod,
    input  cbmf_pkg::t_pix      i_alpha,
    output logic                o_valid,
    input  logic                i_stall,
    output cbmf_pkg::t_rgb      o_rgb,
    output cbmf_pkg::t_pix      o_alpha
);
    import cbmf_pkg::*;

    logic             r_valid;
    t_rgb             r_rgb;
    t_pix             r_alpha;
    t_rgb             n_rgb;
    logic [SUM_W-1:0] sum [CH_N];
    logic             load;

    assign o_stall = r_valid & i_stall;
    assign load    = ~o_stall;

    always_comb begin
        for (int o = 0; o < CH_N; o++) begin
            sum[o] = SUM_W'(i_prod[o][CH_RED]) + SUM_W'(i_prod[o][CH_GREEN])
                   + SUM_W'(i_prod[o][CH_BLUE]);
            if (|sum[o][SUM_W-1:COEF_FRAC_BITS+PIX_W]) begin
                n_rgb[o] = '1;
            end else begin
                n_rgb[o] = sum[o][COEF_FRAC_BITS +: PIX_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_rgb   <= n_rgb;
            r_alpha <= i_alpha;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;
    assign o_alpha = r_alpha;

endmodule

>>> design/color_blindness_matrix_filter_top.sv
// Top level of the colour vision deficiency matrix filter.
// Throughput is one pixel per cycle when the output does not stall, through three registered
// stages: weight lookup, multiply and sum with saturation; an empty stage still takes a pixel
// while the output stalls.
// Reset is synchronous and active low; it empties the pipeline and sets the preset to zero.
module color_blindness_matrix_filter_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    input  logic [7:0]            i_alpha_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic [7:0]            o_alpha_out
);
    import cbmf_pkg::*;

    t_sel      r_preset;
    t_rgb      in_rgb;
    logic      v1;
    logic      v2;
    logic      stall1;
    logic      stall2;
    logic      stall3;
    t_rgb      rgb1;
    t_pix      alpha1;
    t_mat      mat1;
    t_prod_mat prod2;
    t_pix      alpha2;
    t_rgb      rgb3;
    t_pix      alpha3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= '0;
        end else if (i_cfg_wr_en) begin
            r_preset <= i_cfg_wr_data;
        end
    end

    assign in_rgb[CH_RED]   = i_red_in;
    assign in_rgb[CH_GREEN] = i_green_in;
    assign in_rgb[CH_BLUE]  = i_blue_in;

    cbmf_coef u_coef (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (stall1),
        .i_rgb    (in_rgb),
        .i_alpha  (i_alpha_in),
        .i_preset (r_preset),
        .o_valid  (v1),
        .i_stall  (stall2),
        .o_rgb    (rgb1),
        .o_alpha  (alpha1),
        .o_mat    (mat1)
    );

    cbmf_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_stall (stall2),
        .i_rgb   (rgb1),
        .i_alpha (alpha1),
        .i_mat   (mat1),
        .o_valid (v2),
        .i_stall (stall3),
        .o_prod  (prod2),
        .o_alpha (alpha2)
    );

    cbmf_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_stall (stall3),
        .i_prod  (prod2),
        .i_alpha (alpha2),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rgb   (rgb3),
        .o_alpha (alpha3)
    );

    assign o_stall     = stall1;
    assign o_red_out   = rgb3[CH_RED];
    assign o_green_out = rgb3[CH_GREEN];
    assign o_blue_out  = rgb3[CH_BLUE];
    assign o_alpha_out = alpha3;

    a_in_to_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> v1)
        else $error("accepted pixel did not reach the first stage");

    a_stage1_to_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v1 && !stall1) |=> v2)
        else $error("pixel lost between the first and second stages");

    a_stage2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v2 && !stall2) |=> o_valid)
        else $error("pixel lost between the second stage and the output");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (v1 && v2 && o_valid && i_stall))
        else $error("input stalled while the pipeline has room");

endmodule

>>> bench/color_blindness_matrix_filter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the colour vision deficiency matrix filter top level.
module color_blindness_matrix_filter_top_test;
    import cbmf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        t_pix alpha;
    } t_pixel;

    localparam int unsigned CVD_PCT [N_PRESET][CH_N][CH_N] = '{
        '{'{56, 44,  0}, '{55, 45,  0}, '{ 0, 24, 76}},
        '{'{82, 18,  0}, '{33, 67,  0}, '{ 0, 13, 87}},
        '{'{63, 37,  0}, '{70, 30,  0}, '{ 0, 30, 70}},
        '{'{80, 20,  0}, '{26, 74,  0}, '{ 0, 15, 85}},
        '{'{95,  5,  0}, '{ 0, 44, 56}, '{ 0, 48, 52}},
        '{'{97,  3,  0}, '{ 0, 73, 27}, '{ 0, 18, 82}},
        '{'{30, 59, 11}, '{30, 59, 11}, '{30, 59, 11}},
        '{'{62, 32,  6}, '{16, 78,  6}, '{16, 32, 52}}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [2:0] i_cfg_wr_data = '0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    t_pix       i_red_in      = '0;
    t_pix       i_green_in    = '0;
    t_pix       i_blue_in     = '0;
    t_pix       i_alpha_in    = '0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    t_pix       o_red_out;
    t_pix       o_green_out;
    t_pix       o_blue_out;
    t_pix       o_alpha_out;

    t_pixel expected_pixels [$];
    t_sel   model_preset   = '0;
    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    int     hold_left      = 0;
    int     mismatch_count = 0;
    int     cycle_count    = 0;

    color_blindness_matrix_filter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_alpha_in    (i_alpha_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_alpha_out   (o_alpha_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_pixel filter_pixel(input t_sel preset, input t_pixel px);
        int unsigned weight [CH_N];
        int unsigned acc;
        t_pix        chan [CH_N];
        for (int o = 0; o < CH_N; o++) begin
            for (int i = 0; i < CH_N; i++) begin
                weight[i] = (CVD_PCT[preset][o][i] * (1 << COEF_FRAC_BITS) + 50) / 100;
            end
            acc = px.red * weight[0] + px.green * weight[1] + px.blue * weight[2];
            acc = acc >> COEF_FRAC_BITS;
            chan[o] = (acc > 255) ? 8'hFF : t_pix'(acc);
        end
        return '{red: chan[CH_RED], green: chan[CH_GREEN], blue: chan[CH_BLUE],
                 alpha: px.alpha};
    endfunction

    function automatic t_pix random_level();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return t_pix'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("Output transfer with no pixel outstanding.");
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_red_out !== want.red) begin
                    $error("red_out: expected %0d, actual %0d", want.red, o_red_out);
                    mismatch_count++;
                end
                if (o_green_out !== want.green) begin
                    $error("green_out: expected %0d, actual %0d", want.green, o_green_out);
                    mismatch_count++;
                end
                if (o_blue_out !== want.blue) begin
                    $error("blue_out: expected %0d, actual %0d", want.blue, o_blue_out);
                    mismatch_count++;
                end
                if (o_alpha_out !== want.alpha) begin
                    $error("alpha_out: expected %0d, actual %0d", want.alpha, o_alpha_out);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        i_alpha_in <= px.alpha;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_pixels.push_back(filter_pixel(model_preset, px));
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_preset(input t_sel value);
        drain_pipeline();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_preset = value;
    endtask

    task automatic test_reset_preset();
        send_pixel('{red: 8'hFF, green: 8'h00, blue: 8'h80, alpha: 8'h3C});
        send_pixel('{red: 8'h12, green: 8'hEE, blue: 8'hFF, alpha: 8'hC3});
    endtask

    task automatic test_preset_extremes();
        t_pix hot;
        for (int p = 0; p < N_PRESET; p++) begin
            write_preset(t_sel'(p));
            hot = 8'hFF;
            send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00});
            send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF});
            send_pixel('{red: (p % 3 == 0) ? hot : 8'h00, green: (p % 3 == 1) ? hot : 8'h00,
                         blue: (p % 3 == 2) ? hot : 8'h00, alpha: 8'h5A});
        end
    endtask

    task automatic test_backpressure_fill();
        drain_pipeline();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left <= HOLD_CYCLES;
        for (int k = 0; k < 40; k++) begin
            send_pixel('{red: random_level(), green: random_level(),
                         blue: random_level(), alpha: random_level()});
        end
    endtask

    task automatic test_random_stream(input int n_items, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 150 == 0) write_preset(t_sel'($urandom_range(N_PRESET - 1)));
            send_pixel('{red: random_level(), green: random_level(),
                         blue: random_level(), alpha: random_level()});
        end
    endtask

    task automatic finish_run();
        i_valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_pixels.size() != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d pixels never came out.", expected_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_preset();
        test_preset_extremes();
        test_backpressure_fill();
        test_random_stream(600, 22, 65);
        test_random_stream(600, 65, 22);
        test_random_stream(650, 0, 0);
        finish_run();
    end

endmodule
